FILE: rtl/ntg_pkg.sv
`timescale 1ns / 1ps
// Package for the note square-wave tone generator: field widths, command and
// letter codes, the semitone ratio table and the structs passed between modules.
package ntg_pkg;

	localparam int DUR_W   = 16;
	localparam int FREQ_W  = 24;  // unsigned Q16.8 Hz
	localparam int HALF_W  = 15;
	localparam int CYC_W   = 16;
	localparam int PAUSE_W = 26;

	// floor(x / 125) = (x * RECIP_125) >> RECIP_SH, exact for x < 2^24
	localparam logic [23:0] RECIP_125 = 24'd8589935;
	localparam int          RECIP_SH  = 30;
	// 125 * 65536: at or above this the cycle count saturates
	localparam logic [22:0] CYC_SAT_LIMIT = 23'd8192000;
	localparam logic [CYC_W-1:0] CYC_MAX = '1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [3:0] LTR_A     = 4'd0;
	localparam logic [3:0] LTR_B     = 4'd1;
	localparam logic [3:0] LTR_C     = 4'd2;
	localparam logic [3:0] LTR_D     = 4'd3;
	localparam logic [3:0] LTR_E     = 4'd4;
	localparam logic [3:0] LTR_F     = 4'd5;
	localparam logic [3:0] LTR_G     = 4'd6;
	localparam logic [3:0] LTR_PAUSE = 4'd7;

	localparam logic [1:0] ACC_SHARP = 2'd1;
	localparam logic [1:0] ACC_FLAT  = 2'd2;

	// round(2^(s/12) * 1e9)
	localparam longint unsigned SEMI_RATIO [12] = '{
		64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
		64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
		64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
	};

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_TONE  = 2'd1,
		MODE_PAUSE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_TONE  = 2'd1,
		OP_PAUSE = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [HALF_W-1:0]  half;
		logic [CYC_W-1:0]   cycles;
		logic [PAUSE_W-1:0] pause_us;
	} note_evt_t;

	typedef struct packed {
		logic level;
		logic busy;
		logic done;
		logic bad;
	} player_out_t;

	// semitone offset of a letter from A in the same octave, plus 12
	function automatic logic [3:0] letter_base(input logic [3:0] letter);
		logic [3:0] base;
		case (letter)
			LTR_A:   base = 4'd12;
			LTR_B:   base = 4'd14;
			LTR_C:   base = 4'd3;
			LTR_D:   base = 4'd5;
			LTR_E:   base = 4'd7;
			LTR_F:   base = 4'd8;
			LTR_G:   base = 4'd10;
			default: base = 4'd12;
		endcase
		return base;
	endfunction

endpackage

FILE: rtl/ntg_cmd_if.sv
`timescale 1ns / 1ps
// Note command channel: valid/ready handshake with the note or tick word.
// Stands alone; widths match ntg_pkg.
interface ntg_cmd_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [3:0]  note_letter;
	logic [3:0]  octave;
	logic [1:0]  accidental;
	logic [15:0] duration_ms;

	modport source (
		output valid, command, note_letter, octave, accidental, duration_ms,
		input  ready
	);
	modport sink (
		input  valid, command, note_letter, octave, accidental, duration_ms,
		output ready
	);
endinterface

FILE: rtl/ntg_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the pin level and status word.
// Stands alone.
interface ntg_res_if;
	logic valid;
	logic ready;
	logic buzzer_level;
	logic busy_res;
	logic note_done;
	logic bad_note;

	modport source (
		output valid, buzzer_level, busy_res, note_done, bad_note,
		input  ready
	);
	modport sink (
		input  valid, buzzer_level, busy_res, note_done, bad_note,
		output ready
	);
endinterface

FILE: rtl/ntg_note_calc.sv
`timescale 1ns / 1ps
// Note lookup: semitone index from letter, octave and accidental, then the
// constant frequency and half-period tables. Depends on ntg_pkg.
module ntg_note_calc #(
	parameter int NUM_OCTAVES = 10
) (
	input  logic [3:0]                 note_letter,
	input  logic [3:0]                 octave,
	input  logic [1:0]                 accidental,
	output logic [ntg_pkg::FREQ_W-1:0] freq,
	output logic [ntg_pkg::HALF_W-1:0] half
);
	import ntg_pkg::*;

	// index = d + 60, where d is the semitone distance from A4
	localparam int TAB_DEPTH = NUM_OCTAVES * 12 + 4;
	localparam int IDX_W     = $clog2(TAB_DEPTH);

	logic [FREQ_W-1:0] freq_tab [TAB_DEPTH];
	logic [HALF_W-1:0] half_tab [TAB_DEPTH];
	logic [3:0]        oct_sat;
	logic [3:0]        base;
	logic              inc;
	logic              dec;
	logic [IDX_W-1:0]  idx;

	for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
		localparam int KS    = i / 12 - 5;
		localparam int SH_UP = (KS >= 0) ? KS : 0;
		localparam int SH_DN = (KS < 0) ? -KS : 0;
		localparam longint unsigned RATIO = SEMI_RATIO[i % 12];
		localparam longint unsigned FNUM  = (64'd112640 * RATIO) << SH_UP;
		localparam longint unsigned FDEN  = 64'd1000000000 << SH_DN;
		localparam longint unsigned FVAL  = (FNUM + FDEN / 2) / FDEN;
		localparam longint unsigned PER   =
			(64'd1000000000000000 << SH_DN) / ((64'd440 * RATIO) << SH_UP);
		localparam longint unsigned HRAW  = PER / 2;
		localparam longint unsigned HVAL  =
			(HRAW > 64'd32767) ? 64'd32767 : ((HRAW == 64'd0) ? 64'd1 : HRAW);
		assign freq_tab[i] = FREQ_W'(FVAL);
		assign half_tab[i] = HALF_W'(HVAL);
	end

	always_comb begin
		oct_sat = (octave >= 4'(NUM_OCTAVES)) ? 4'(NUM_OCTAVES - 1) : octave;
		base    = letter_base(note_letter);
		inc     = (accidental == ACC_SHARP);
		dec     = (accidental == ACC_FLAT);
		idx     = IDX_W'({28'd0, oct_sat} * 32'd12 + {28'd0, base}
			+ {31'd0, inc} - {31'd0, dec});
		freq    = freq_tab[idx];
		half    = half_tab[idx];
	end

endmodule

FILE: rtl/ntg_player.sv
`timescale 1ns / 1ps
// Playback state machine: tone half-period and cycle counters, pause counter
// and pin level, stepped once per decoded word. Depends on ntg_pkg.
module ntg_player (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  ntg_pkg::note_evt_t   evt,
	output ntg_pkg::player_out_t res
);
	import ntg_pkg::*;

	mode_t              mode_q, mode_d;
	logic [HALF_W-1:0]  hp_q, hp_d;
	logic [HALF_W-1:0]  hc_q, hc_d;
	logic [CYC_W-1:0]   cl_q, cl_d;
	logic [PAUSE_W-1:0] pl_q, pl_d;
	logic               pin_q, pin_d;
	logic [HALF_W-1:0]  hc_dec;
	logic [HALF_W-1:0]  hp_reload;
	logic [CYC_W-1:0]   cl_dec;
	logic [PAUSE_W-1:0] pl_dec;
	logic               done;
	logic               bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hp_q   <= '0;
			hc_q   <= '0;
			cl_q   <= '0;
			pl_q   <= '0;
			pin_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			hp_q   <= hp_d;
			hc_q   <= hc_d;
			cl_q   <= cl_d;
			pl_q   <= pl_d;
			pin_q  <= pin_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		hp_d      = hp_q;
		hc_d      = hc_q;
		cl_d      = cl_q;
		pl_d      = pl_q;
		pin_d     = pin_q;
		done      = 1'b0;
		bad       = 1'b0;
		hc_dec    = (hc_q != '0) ? hc_q - 1'b1 : hc_q;
		cl_dec    = (cl_q != '0) ? cl_q - 1'b1 : cl_q;
		pl_dec    = (pl_q != '0) ? pl_q - 1'b1 : pl_q;
		hp_reload = (hp_q == '0) ? HALF_W'(1) : hp_q;
		case (evt.op)
			OP_BAD: begin
				bad = 1'b1;
			end
			OP_PAUSE: begin
				mode_d = MODE_IDLE;
				hc_d   = '0;
				cl_d   = '0;
				pl_d   = '0;
				pin_d  = 1'b0;
				if (evt.pause_us == '0) begin
					done = 1'b1;
				end else begin
					mode_d = MODE_PAUSE;
					pl_d   = evt.pause_us;
				end
			end
			OP_TONE: begin
				mode_d = MODE_IDLE;
				hc_d   = '0;
				cl_d   = '0;
				pl_d   = '0;
				pin_d  = 1'b0;
				hp_d   = evt.half;
				if (evt.cycles == '0) begin
					done = 1'b1;
				end else begin
					mode_d = MODE_TONE;
					cl_d   = evt.cycles;
					hc_d   = evt.half;
					pin_d  = 1'b1;
				end
			end
			OP_TICK: begin
				case (mode_q)
					MODE_TONE: begin
						hc_d = hc_dec;
						if (hc_dec == '0) begin
							if (pin_q) begin
								pin_d = 1'b0;
								hc_d  = hp_reload;
							end else if (cl_dec == '0) begin
								// last low half done: end the tone
								mode_d = MODE_IDLE;
								hc_d   = '0;
								cl_d   = '0;
								pl_d   = '0;
								done   = 1'b1;
							end else begin
								pin_d = 1'b1;
								hc_d  = hp_reload;
								cl_d  = cl_dec;
							end
						end
					end
					MODE_PAUSE: begin
						pl_d = pl_dec;
						if (pl_dec == '0) begin
							mode_d = MODE_IDLE;
							done   = 1'b1;
						end
					end
					MODE_IDLE: begin
					end
					default: begin
						mode_d = MODE_IDLE;
						hc_d   = '0;
						cl_d   = '0;
						pl_d   = '0;
						pin_d  = 1'b0;
					end
				endcase
			end
			default: begin
			end
		endcase
		res.level = pin_d;
		res.busy  = (mode_d != MODE_IDLE);
		res.done  = done;
		res.bad   = bad;
	end

endmodule

FILE: rtl/note_square_wave_tone_generator.sv
`timescale 1ns / 1ps
// Top level of one buzzer voice: input register, note lookup, cycle-count
// pipeline, playback state machine and result register. Depends on ntg_pkg,
// ntg_cmd_if, ntg_res_if, ntg_note_calc and ntg_player.
//
// Usage:
//  - cmd carries one word per handshake: a load (note letter, octave,
//    accidental, duration in ms) or a tick that stands for one microsecond.
//  - res returns exactly one word per accepted command word, in order: pin
//    level, busy, note done and bad note, all as they stand after that word.
//  - Pipeline: an accepted word passes through the input register, table
//    lookup, frequency times duration, divide by 256000 through a reciprocal
//    multiply, then the state update into the result register.
//  - Throughput: one word per clock cycle while res is taken; the playback
//    counters update with each word, so ticks can stream back to back.
//  - Stall: when res is not taken, the result holds and the pipeline stages
//    in front keep filling until every stage holds a word; then cmd.ready
//    drops.
//  - Reset: arst_n clears all pipeline valids and returns the voice to idle
//    with the pin low. No clearing pass is needed.
module note_square_wave_tone_generator #(
	parameter int NUM_OCTAVES = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	ntg_cmd_if.sink    cmd,
	ntg_res_if.source  res
);
	import ntg_pkg::*;

	// stage 1: accepted word
	logic               v_s1;
	logic               command_s1;
	logic [3:0]         letter_s1;
	logic [3:0]         octave_s1;
	logic [1:0]         acc_s1;
	logic [DUR_W-1:0]   dur_s1;

	// stage 2: decoded op and table values
	logic               v_s2;
	op_t                op_s2;
	logic [FREQ_W-1:0]  freq_s2;
	logic [HALF_W-1:0]  half_s2;
	logic [DUR_W-1:0]   dur_s2;
	logic [PAUSE_W-1:0] pause_s2;

	// stage 3: frequency times duration, divided by 2048
	logic               v_s3;
	op_t                op_s3;
	logic [HALF_W-1:0]  half_s3;
	logic [PAUSE_W-1:0] pause_s3;
	logic               sat_s3;
	logic [22:0]        x_s3;

	// stage 4: finished note word
	logic               v_s4;
	note_evt_t          evt_s4;

	logic               out_valid_q;
	player_out_t        res_q;

	logic               en1, en2, en3, en4, en_out;
	op_t                op_dec;
	logic [FREQ_W-1:0]  freq_lk;
	logic [HALF_W-1:0]  half_lk;
	logic [39:0]        prod_f;
	logic [46:0]        prod_r;
	logic [CYC_W-1:0]   cyc;
	player_out_t        res_d;

	// a stage advances when it is empty or the next one advances
	assign en_out    = !out_valid_q || res.ready;
	assign en4       = !v_s4 || en_out;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign cmd.ready = en1;

	always_comb begin
		if (command_s1 == CMD_TICK) begin
			op_dec = OP_TICK;
		end else if (letter_s1 > LTR_PAUSE) begin
			op_dec = OP_BAD;
		end else if (letter_s1 == LTR_PAUSE) begin
			op_dec = OP_PAUSE;
		end else begin
			op_dec = OP_TONE;
		end
	end

	ntg_note_calc #(
		.NUM_OCTAVES(NUM_OCTAVES)
	) u_calc (
		.note_letter(letter_s1),
		.octave     (octave_s1),
		.accidental (acc_s1),
		.freq       (freq_lk),
		.half       (half_lk)
	);

	assign prod_f = {16'd0, freq_s2} * {24'd0, dur_s2};
	assign prod_r = {24'd0, x_s3} * {23'd0, RECIP_125};
	assign cyc    = sat_s3 ? CYC_MAX : prod_r[RECIP_SH +: CYC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en_out) out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			command_s1 <= cmd.command;
			letter_s1  <= cmd.note_letter;
			octave_s1  <= cmd.octave;
			acc_s1     <= cmd.accidental;
			dur_s1     <= cmd.duration_ms;
		end
		if (en2 && v_s1) begin
			op_s2    <= op_dec;
			freq_s2  <= freq_lk;
			half_s2  <= half_lk;
			dur_s2   <= dur_s1;
			pause_s2 <= PAUSE_W'(dur_s1) * PAUSE_W'(1000);
		end
		if (en3 && v_s2) begin
			op_s3    <= op_s2;
			half_s3  <= half_s2;
			pause_s3 <= pause_s2;
			sat_s3   <= (prod_f[39:11] >= {6'd0, CYC_SAT_LIMIT});
			x_s3     <= prod_f[33:11];
		end
		if (en4 && v_s3) begin
			evt_s4.op       <= op_s3;
			evt_s4.half     <= half_s3;
			evt_s4.cycles   <= cyc;
			evt_s4.pause_us <= pause_s3;
		end
		if (en_out && v_s4) begin
			res_q <= res_d;
		end
	end

	ntg_player u_player (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (en_out && v_s4),
		.evt   (evt_s4),
		.res   (res_d)
	);

	assign res.valid        = out_valid_q;
	assign res.buzzer_level = res_q.level;
	assign res.busy_res     = res_q.busy;
	assign res.note_done    = res_q.done;
	assign res.bad_note     = res_q.bad;

endmodule

FILE: rtl/ntg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tone generator, bound to the top level.
// Depends on note_square_wave_tone_generator and its channel interfaces.
module ntg_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic buzzer_level,
	input logic busy_res,
	input logic note_done,
	input logic bad_note
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid
			&& $stable(buzzer_level) && $stable(busy_res)
			&& $stable(note_done) && $stable(bad_note))
		else $error("result word changed while stalled");

	// a finished note leaves the voice idle with the pin low
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && note_done |-> !busy_res && !buzzer_level)
		else $error("note done while still busy or pin high");

	// the pin is only driven high while a tone runs
	a_idle_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> !buzzer_level)
		else $error("pin high while idle");

	// a rejected note never ends the note in progress
	a_bad_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && bad_note |-> !note_done)
		else $error("bad note reported together with note done");

endmodule

bind note_square_wave_tone_generator ntg_checker u_ntg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.buzzer_level(res.buzzer_level),
	.busy_res    (res.busy_res),
	.note_done   (res.note_done),
	.bad_note    (res.bad_note)
);

FILE: tb/note_square_wave_tone_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for one buzzer voice: a directed note table, then random
// note/tick sequences under sender and receiver idling, checked against a voice model.
// Depends on ntg_pkg, ntg_cmd_if, ntg_res_if and note_square_wave_tone_generator.
module note_square_wave_tone_generator_tb;
	import ntg_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RST_CYCLES  = 9;
	localparam int NUM_OCT     = 10;
	localparam int RAND_WORDS  = 1250;
	localparam int PHASE_LEN   = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_AT    = 700;
	localparam int TAIL_CYCLES = 16;
	localparam int LIMIT       = 1500000;
	localparam int unsigned NEVER = 32'hFFFF_FFFF;

	localparam logic [1:0] ACC_NAT    = 2'd0;
	localparam logic [1:0] ACC_UNUSED = 2'd3;
	localparam logic [3:0] LTR_BAD_LO = 4'd8;
	localparam logic [3:0] LTR_BAD_HI = 4'd15;

	// round(2^(s/12) * 1e9)
	localparam longint unsigned SEMI_STEP [12] = '{
		64'd1000000000, 64'd1059463094, 64'd1122462048, 64'd1189207115,
		64'd1259921050, 64'd1334839854, 64'd1414213562, 64'd1498307077,
		64'd1587401052, 64'd1681792831, 64'd1781797436, 64'd1887748625
	};
	// semitones from A within the octave, letters A..G
	localparam int LETTER_SEMI [7] = '{0, 2, -9, -7, -5, -4, -2};

	typedef struct packed {
		logic        command;
		logic [3:0]  letter;
		logic [3:0]  octave;
		logic [1:0]  acc;
		logic [15:0] dur;
	} note_word_t;

	typedef struct packed {
		logic buzzer_level;
		logic busy_res;
		logic note_done;
		logic bad_note;
	} voice_status_t;

	typedef struct packed {
		note_word_t    w;
		logic          typed;
		voice_status_t st;
	} note_row_t;

	localparam int DIR_N = 24;
	// status columns: buzzer_level busy_res note_done bad_note
	localparam note_row_t NOTE_ROWS [DIR_N] = '{
		'{'{CMD_TICK, LTR_A, 4'd0, ACC_NAT, 16'd0}, 1'b1, 4'b0000},
		'{'{CMD_LOAD, LTR_BAD_HI, 4'd4, ACC_NAT, 16'hFFFF}, 1'b1, 4'b0001},
		'{'{CMD_LOAD, LTR_PAUSE, 4'd4, ACC_NAT, 16'd0}, 1'b1, 4'b0010},
		'{'{CMD_LOAD, LTR_A, 4'd0, ACC_NAT, 16'd1}, 1'b1, 4'b0010},
		'{'{CMD_LOAD, LTR_B, 4'd9, ACC_SHARP, 16'hFFFF}, 1'b1, 4'b1100},
		'{'{CMD_TICK, LTR_BAD_HI, 4'd15, ACC_UNUSED, 16'hFFFF}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_BAD_LO, 4'd4, ACC_NAT, 16'd5}, 1'b1, 4'b1101},
		'{'{CMD_LOAD, LTR_C, 4'd15, ACC_FLAT, 16'd2}, 1'b1, 4'b1100},
		'{'{CMD_LOAD, LTR_G, 4'd0, ACC_UNUSED, 16'd40}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_A, 4'd4, ACC_NAT, 16'd1}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_B, 4'd4, ACC_SHARP, 16'd3}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_C, 4'd4, ACC_FLAT, 16'd5}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_D, 4'd5, ACC_NAT, 16'd7}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_E, 4'd3, ACC_SHARP, 16'd11}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_F, 4'd6, ACC_FLAT, 16'd100}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_G, 4'd7, ACC_NAT, 16'd1}, 1'b0, 4'b0000},
		'{'{CMD_TICK, LTR_A, 4'd0, ACC_NAT, 16'd0}, 1'b0, 4'b0000},
		'{'{CMD_TICK, LTR_G, 4'd9, ACC_FLAT, 16'h5A5A}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_PAUSE, 4'd0, ACC_NAT, 16'd1}, 1'b1, 4'b0100},
		'{'{CMD_TICK, LTR_A, 4'd0, ACC_NAT, 16'd0}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_PAUSE, 4'd9, ACC_UNUSED, 16'hFFFF}, 1'b1, 4'b0100},
		'{'{CMD_TICK, LTR_A, 4'd0, ACC_NAT, 16'd0}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, LTR_E, 4'd2, ACC_NAT, 16'hFFFF}, 1'b0, 4'b0000},
		'{'{CMD_LOAD, 4'd12, 4'd1, ACC_SHARP, 16'd9}, 1'b0, 4'b0000}
	};

	logic clk = 1'b0;
	logic arst_n;

	ntg_cmd_if cmd ();
	ntg_res_if res ();

	note_square_wave_tone_generator #(
		.NUM_OCTAVES(NUM_OCT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// voice model state
	mode_t       v_mode;
	logic [14:0] v_half_len;
	logic [14:0] v_half_cnt;
	logic [15:0] v_cyc_left;
	logic [25:0] v_pause_left;
	logic        v_pin;

	voice_status_t pin_status_q [$];
	int          err_cnt = 0;
	int          word_cnt;
	bit          hold_req;
	bit          draining;
	int          cycle_cnt = 0;

	function automatic longint unsigned tone_freq_q8(int k, int s);
		longint unsigned num, den;
		num = 64'd112640 * SEMI_STEP[s];
		if (k >= 0)
			return ((num << k) + 64'd500000000) / 64'd1000000000;
		den = 64'd1000000000 << (-k);
		return (num + den / 2) / den;
	endfunction

	function automatic longint unsigned tone_period_us(int k, int s);
		longint unsigned base;
		base = 64'd440 * SEMI_STEP[s];
		if (k >= 0)
			return 64'd1000000000000000 / (base << k);
		return (64'd1000000000000000 << (-k)) / base;
	endfunction

	task automatic voice_idle();
		v_mode = MODE_IDLE;
		v_half_cnt = '0;
		v_cyc_left = '0;
		v_pause_left = '0;
		v_pin = 1'b0;
	endtask

	task automatic voice_step(input note_word_t w, output voice_status_t st);
		int d, idx, k, s, oct;
		longint unsigned f, cyc, half;
		logic done, bad;
		done = 1'b0;
		bad = 1'b0;
		if (w.command == CMD_LOAD) begin
			if (w.letter > LTR_PAUSE) begin
				bad = 1'b1;
			end else if (w.letter == LTR_PAUSE) begin
				voice_idle();
				if (w.dur == 16'd0) begin
					done = 1'b1;
				end else begin
					v_mode = MODE_PAUSE;
					v_pause_left = 26'(32'(w.dur) * 32'd1000);
				end
			end else begin
				oct = int'(w.octave);
				if (oct >= NUM_OCT)
					oct = NUM_OCT - 1;
				d = (oct - 4) * 12 + LETTER_SEMI[w.letter];
				if (w.acc == ACC_SHARP)
					d = d + 1;
				else if (w.acc == ACC_FLAT)
					d = d - 1;
				idx = d + 60;
				k = idx / 12 - 5;
				s = idx % 12;
				f = tone_freq_q8(k, s);
				cyc = (f * w.dur) / 64'd256000;
				if (cyc > 64'd65535)
					cyc = 64'd65535;
				half = tone_period_us(k, s) / 2;
				if (half > 64'd32767)
					half = 64'd32767;
				if (half == 64'd0)
					half = 64'd1;
				voice_idle();
				v_half_len = half[14:0];
				if (cyc == 64'd0) begin
					done = 1'b1;
				end else begin
					v_mode = MODE_TONE;
					v_cyc_left = cyc[15:0];
					v_half_cnt = half[14:0];
					v_pin = 1'b1;
				end
			end
		end else if (v_mode == MODE_TONE) begin
			if (v_half_cnt > 0)
				v_half_cnt = v_half_cnt - 1'b1;
			if (v_half_cnt == 0) begin
				if (v_pin) begin
					v_pin = 1'b0;
					v_half_cnt = v_half_len;
				end else begin
					// low half done: one full cycle gone
					if (v_cyc_left > 0)
						v_cyc_left = v_cyc_left - 1'b1;
					if (v_cyc_left == 0) begin
						voice_idle();
						done = 1'b1;
					end else begin
						v_pin = 1'b1;
						v_half_cnt = v_half_len;
					end
				end
				if (v_mode == MODE_TONE && v_half_cnt == 0)
					v_half_cnt = 15'd1;
			end
		end else if (v_mode == MODE_PAUSE) begin
			if (v_pause_left > 0)
				v_pause_left = v_pause_left - 1'b1;
			if (v_pause_left == 0) begin
				voice_idle();
				done = 1'b1;
			end
		end
		st = '{v_pin, v_mode != MODE_IDLE, done, bad};
	endtask

	function automatic int idle_pct(bit rx_side);
		case ((word_cnt / PHASE_LEN) % 4)
			1: return rx_side ? 0 : 85;
			2: return rx_side ? 85 : 0;
			3: return 32;
			default: return 0;
		endcase
	endfunction

	// offer one word, wait for the handshake, then predict its status
	task automatic send_word(input note_word_t w, input bit typed, input voice_status_t typed_st,
			output voice_status_t st);
		while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= w.command;
		cmd.note_letter <= w.letter;
		cmd.octave <= w.octave;
		cmd.accidental <= w.acc;
		cmd.duration_ms <= w.dur;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		voice_step(w, st);
		pin_status_q.push_back(typed ? typed_st : st);
		word_cnt++;
	endtask

	function automatic void check_field(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			err_cnt++;
		end
	endfunction

	// result side: check each taken word, then pick the next ready
	initial begin
		voice_status_t want;
		int hold_cnt;
		hold_cnt = 0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				if (pin_status_q.size() == 0) begin
					$error("result word with no note word pending");
					err_cnt++;
				end else begin
					want = pin_status_q.pop_front();
					check_field("buzzer_level", want.buzzer_level, res.buzzer_level);
					check_field("busy_res", want.busy_res, res.busy_res);
					check_field("note_done", want.note_done, res.note_done);
					check_field("bad_note", want.bad_note, res.bad_note);
				end
			end
			if (hold_req && hold_cnt < HOLD_CYCLES) begin
				res.ready <= 1'b0;
				hold_cnt++;
			end else if (draining) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
			end
		end
	end

	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** note_square_wave_tone_generator: FAILED **");
		$finish;
	end

	initial begin
		note_word_t    w;
		voice_status_t st;
		int unsigned   run_ticks, cut_at, r;
		bit            drained;

		word_cnt = 0;
		hold_req = 1'b0;
		draining = 1'b0;
		drained = 1'b0;
		voice_idle();
		v_half_len = '0;
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.command <= CMD_TICK;
		cmd.note_letter <= LTR_A;
		cmd.octave <= 4'd0;
		cmd.accidental <= ACC_NAT;
		cmd.duration_ms <= 16'd0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_word(NOTE_ROWS[i].w, NOTE_ROWS[i].typed, NOTE_ROWS[i].st, st);

		// hold the result side off while words keep coming, to fill the pipe
		hold_req = 1'b1;
		run_ticks = 0;
		cut_at = $urandom_range(0, 40);
		while (word_cnt < DIR_N + RAND_WORDS) begin
			if (!drained && word_cnt >= DRAIN_AT) begin
				drained = 1'b1;
				cmd.valid <= 1'b0;
				@(posedge clk);
				while (pin_status_q.size() != 0)
					@(posedge clk);
			end
			w.command = CMD_TICK;
			w.letter = 4'($urandom_range(0, 15));
			w.octave = 4'($urandom_range(0, 15));
			w.acc = 2'($urandom_range(0, 3));
			w.dur = 16'($urandom_range(0, 65535));
			if (v_mode == MODE_IDLE ? ($urandom_range(0, 9) != 0) : (run_ticks >= cut_at)) begin
				w.command = CMD_LOAD;
				r = $urandom_range(0, 99);
				if (r < 70)
					w.letter = 4'($urandom_range(LTR_A, LTR_G));
				else if (r < 85)
					w.letter = LTR_PAUSE;
				else
					w.letter = 4'($urandom_range(LTR_BAD_LO, LTR_BAD_HI));
				r = $urandom_range(0, 99);
				if (r < 60)
					w.dur = 16'd1;
				else if (r < 75)
					w.dur = 16'd0;
				else if (r < 88)
					w.dur = 16'($urandom_range(2, 3));
			end
			send_word(w, 1'b0, '0, st);
			if (w.command == CMD_TICK) begin
				run_ticks++;
			end else if (w.letter <= LTR_PAUSE) begin
				// plan when this note gets cut short, if at all
				run_ticks = 0;
				if (w.dur > 16'd3 || $urandom_range(0, 99) < 20)
					cut_at = $urandom_range(0, 900);
				else
					cut_at = NEVER;
			end
		end
		cmd.valid <= 1'b0;
		draining = 1'b1;
		@(posedge clk);
		while (pin_status_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("** note_square_wave_tone_generator: PASSED **");
		else
			$display("** note_square_wave_tone_generator: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
rtl/ntg_pkg.sv
rtl/ntg_cmd_if.sv
rtl/ntg_res_if.sv
rtl/ntg_note_calc.sv
rtl/ntg_player.sv
rtl/note_square_wave_tone_generator.sv
rtl/ntg_checker.sv
tb/note_square_wave_tone_generator_tb.sv
